FILE: hw/rtl/icmp_gen_pkg.sv
// Shared types and constants for the ICMP echo frame generator.
package icmp_gen_pkg;

  localparam int unsigned FRAME_LEN = 42;
  localparam logic [5:0]  LAST_OFS  = 6'(FRAME_LEN - 1);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SOURCE_MAC  = 2'd0,
    REG_DEST_MAC    = 2'd1,
    REG_SOURCE_IPV4 = 2'd2,
    REG_DEST_IPV4   = 2'd3
  } cfg_reg_t;

  // one queued echo request with its ICMP checksum already worked out
  typedef struct packed {
    logic [15:0] ident;
    logic [15:0] seq;
    logic [15:0] icmp_ck;
  } echo_req_t;

  // queue status seen by the back end
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // fixed header words that enter the IPv4 checksum:
  // 0x4500 + 0x001C (total length) + 0x4001 (TTL, protocol)
  localparam logic [15:0] IP_CK_BASE = 16'h851D;
  // ICMP type/code word for an echo request
  localparam logic [15:0] ICMP_TYPE_WORD = 16'h0800;

endpackage

FILE: hw/rtl/icmp_echo_frame_generator.sv
// Top level of the ICMP echo request frame generator.
//
// Usage:
//   Pulse start with in_echo_ident / in_echo_sequence; the request is taken at
//   a clock edge where start is high and busy is low. Each request yields one
//   42-octet Ethernet/IPv4/ICMP echo request frame, one octet per cycle on
//   out_frame_byte, flagged by out_valid, with out_byte_offset 0..41 and
//   out_last_byte set on octet 41.
//   Configuration: cfg_we, cfg_index (0 source MAC, 1 dest MAC, 2 source IPv4,
//   3 dest IPv4), cfg_data; user writes only while idle (not enforced).
// Timing:
//   With the block empty, an accepted request passes the front stage, queue,
//   offset walker and output register before its first octet. Frames go out
//   back to back while requests wait. A front stage plus a QUEUE_DEPTH-entry
//   queue hold pending requests; busy rises only when both are full.
// Reset:
//   rst_n clears all configuration to zero and drops anything pending.
//   The receiver cannot stall; every octet is presented for exactly one cycle.
module icmp_echo_frame_generator
  import icmp_gen_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_echo_ident,
  input  logic [15:0] in_echo_sequence,
  output logic        out_valid,
  output logic [7:0]  out_frame_byte,
  output logic [5:0]  out_byte_offset,
  output logic        out_last_byte,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic [47:0] source_mac_r, dest_mac_r;
  logic [31:0] source_ipv4_r, dest_ipv4_r;
  logic        q_push, q_pop;
  echo_req_t   q_din, q_dout;
  q_status_t   q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_mac_r  <= '0;
      dest_mac_r    <= '0;
      source_ipv4_r <= '0;
      dest_ipv4_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SOURCE_MAC:  source_mac_r  <= cfg_data;
        REG_DEST_MAC:    dest_mac_r    <= cfg_data;
        REG_SOURCE_IPV4: source_ipv4_r <= cfg_data[31:0];
        REG_DEST_IPV4:   dest_ipv4_r   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  icmp_gen_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_echo_ident    (in_echo_ident),
    .in_echo_sequence (in_echo_sequence),
    .q_full           (q_status.full),
    .q_push           (q_push),
    .q_din            (q_din)
  );

  icmp_gen_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .din    (q_din),
    .pop    (q_pop),
    .dout   (q_dout),
    .status (q_status)
  );

  icmp_gen_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .source_mac      (source_mac_r),
    .dest_mac        (dest_mac_r),
    .source_ipv4     (source_ipv4_r),
    .dest_ipv4       (dest_ipv4_r),
    .q_status        (q_status),
    .q_dout          (q_dout),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_frame_byte  (out_frame_byte),
    .out_byte_offset (out_byte_offset),
    .out_last_byte   (out_last_byte)
  );

`ifndef ASSERT_OFF
  // last flag only on the final octet
  a_last_ofs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_byte_offset == LAST_OFS)
    else $error("last beat at wrong offset");

  // a frame is never interrupted once started
  a_frame_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_byte |=>
      out_valid && out_byte_offset == $past(out_byte_offset) + 6'd1)
    else $error("frame beats not contiguous");

  // busy only while the queue is full
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> q_status.full)
    else $error("busy without full queue");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat after reset");
`endif

endmodule

FILE: hw/rtl/icmp_gen_front.sv
// Front end: takes requests, computes the ICMP checksum, hands them to the queue.
module icmp_gen_front
  import icmp_gen_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_echo_ident,
  input  logic [15:0] in_echo_sequence,
  input  logic        q_full,
  output logic        q_push,
  output echo_req_t   q_din
);

  logic        stg_valid_r, stg_valid_nxt;
  echo_req_t   stg_req_r;
  logic        accept;
  logic [17:0] ck_sum;
  logic [16:0] ck_fold1;
  logic [16:0] ck_fold2;

  // one's-complement sum of type word, ident and sequence
  always_comb begin
    ck_sum   = 18'(ICMP_TYPE_WORD) + 18'(in_echo_ident) + 18'(in_echo_sequence);
    ck_fold1 = 17'(ck_sum[15:0]) + 17'(ck_sum[17:16]);
    ck_fold2 = 17'(ck_fold1[15:0]) + 17'(ck_fold1[16]);
  end

  assign q_push = stg_valid_r && !q_full;
  assign busy   = stg_valid_r && q_full;
  assign accept = start && !busy;
  assign q_din  = stg_req_r;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (accept) begin
      stg_valid_nxt = 1'b1;
    end else if (q_push) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_req_r.ident   <= in_echo_ident;
      stg_req_r.seq     <= in_echo_sequence;
      stg_req_r.icmp_ck <= ~ck_fold2[15:0];
    end
  end

endmodule

FILE: hw/rtl/icmp_gen_queue.sv
// Small request queue between the front and back ends.
module icmp_gen_queue
  import icmp_gen_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  echo_req_t din,
  input  logic      pop,
  output echo_req_t dout,
  output q_status_t status
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  echo_req_t         entries_r [DEPTH];
  logic [IW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.valid = (count_r != '0);
  assign dout         = entries_r[rd_ptr_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: hw/rtl/icmp_gen_back.sv
// Back end: walks one frame at a time and emits one octet per cycle.
module icmp_gen_back
  import icmp_gen_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [47:0] source_mac,
  input  logic [47:0] dest_mac,
  input  logic [31:0] source_ipv4,
  input  logic [31:0] dest_ipv4,
  input  q_status_t   q_status,
  input  echo_req_t   q_dout,
  output logic        q_pop,
  output logic        out_valid,
  output logic [7:0]  out_frame_byte,
  output logic [5:0]  out_byte_offset,
  output logic        out_last_byte
);

  logic        active_r, active_nxt;
  logic [5:0]  ofs_r, ofs_nxt;
  echo_req_t   cur_r;
  logic [15:0] ip_ck_r;
  logic [18:0] ip_sum;
  logic [16:0] ip_fold1;
  logic [16:0] ip_fold2;
  logic        at_last;
  logic [7:0]  byte_sel;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [5:0]  out_ofs_r;
  logic        out_last_r;

  // IPv4 header checksum depends on configuration only; kept in a register
  always_comb begin
    ip_sum   = 19'(IP_CK_BASE) + 19'(source_ipv4[31:16]) + 19'(source_ipv4[15:0])
             + 19'(dest_ipv4[31:16]) + 19'(dest_ipv4[15:0]);
    ip_fold1 = 17'(ip_sum[15:0]) + 17'(ip_sum[18:16]);
    ip_fold2 = 17'(ip_fold1[15:0]) + 17'(ip_fold1[16]);
  end

  always_ff @(posedge clk) begin
    ip_ck_r <= ~ip_fold2[15:0];
  end

  assign at_last = (ofs_r == LAST_OFS);
  assign q_pop   = q_status.valid && (!active_r || at_last);

  always_comb begin
    active_nxt = active_r;
    ofs_nxt    = ofs_r;
    if (q_pop) begin
      active_nxt = 1'b1;
      ofs_nxt    = '0;
    end else if (active_r) begin
      if (at_last) begin
        active_nxt = 1'b0;
      end else begin
        ofs_nxt = ofs_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      ofs_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      ofs_r       <= ofs_nxt;
      out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_dout;
    end
  end

  // octet at the current offset, wire order
  always_comb begin
    unique case (ofs_r)
      6'd0:    byte_sel = dest_mac[47:40];
      6'd1:    byte_sel = dest_mac[39:32];
      6'd2:    byte_sel = dest_mac[31:24];
      6'd3:    byte_sel = dest_mac[23:16];
      6'd4:    byte_sel = dest_mac[15:8];
      6'd5:    byte_sel = dest_mac[7:0];
      6'd6:    byte_sel = source_mac[47:40];
      6'd7:    byte_sel = source_mac[39:32];
      6'd8:    byte_sel = source_mac[31:24];
      6'd9:    byte_sel = source_mac[23:16];
      6'd10:   byte_sel = source_mac[15:8];
      6'd11:   byte_sel = source_mac[7:0];
      6'd12:   byte_sel = 8'h08;            // ethertype IPv4
      6'd14:   byte_sel = 8'h45;            // version, IHL
      6'd17:   byte_sel = 8'h1C;            // total length
      6'd22:   byte_sel = 8'd64;            // TTL
      6'd23:   byte_sel = 8'd1;             // protocol ICMP
      6'd24:   byte_sel = ip_ck_r[15:8];
      6'd25:   byte_sel = ip_ck_r[7:0];
      6'd26:   byte_sel = source_ipv4[31:24];
      6'd27:   byte_sel = source_ipv4[23:16];
      6'd28:   byte_sel = source_ipv4[15:8];
      6'd29:   byte_sel = source_ipv4[7:0];
      6'd30:   byte_sel = dest_ipv4[31:24];
      6'd31:   byte_sel = dest_ipv4[23:16];
      6'd32:   byte_sel = dest_ipv4[15:8];
      6'd33:   byte_sel = dest_ipv4[7:0];
      6'd34:   byte_sel = 8'd8;             // echo request
      6'd36:   byte_sel = cur_r.icmp_ck[15:8];
      6'd37:   byte_sel = cur_r.icmp_ck[7:0];
      6'd38:   byte_sel = cur_r.ident[15:8];
      6'd39:   byte_sel = cur_r.ident[7:0];
      6'd40:   byte_sel = cur_r.seq[15:8];
      6'd41:   byte_sel = cur_r.seq[7:0];
      default: byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    out_byte_r <= byte_sel;
    out_ofs_r  <= ofs_r;
    out_last_r <= at_last;
  end

  assign out_valid       = out_valid_r;
  assign out_frame_byte  = out_byte_r;
  assign out_byte_offset = out_ofs_r;
  assign out_last_byte   = out_last_r;

endmodule
